### hdl/dwmd_pkg.sv
// Shared constants for the distinct window marker detector.
// Used by distinct_window_marker_detector_core; no dependencies.
package dwmd_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int RUN_W      = $clog2(MAX_WINDOW + 1);
   localparam int SYM_W      = 8;
   localparam int LEN_W      = 5;
   localparam int POS_W      = 32;
   localparam int LEN_MIN    = 2;

   localparam logic [LEN_W-1:0] LEN_RESET = 5'd4;
   localparam logic [POS_W-1:0] POS_MAX   = '1;

endpackage

### hdl/distinct_window_marker_detector_core.sv
// After input acceptance the core scans S = min(run, MAX_WINDOW-1) prior entries,
// run being the length of the current all-distinct suffix; it skips the scan when S is 0.
// A new symbol is taken only once the response is registered, a limit set by the single
// read port of the byte ring buffer, which is scanned one entry per cycle; a stalled
// response holds the block in its final state until the output register frees.
// Reset (synchronous): count, run length and found flag clear, window_length = 4.
// Ring buffer contents are not cleared; only entries already written are read.
module distinct_window_marker_detector_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [dwmd_pkg::LEN_W-1:0]   csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dwmd_pkg::SYM_W-1:0]   req_symbol,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_marker_found,
   output logic [dwmd_pkg::POS_W-1:0]   rsp_byte_position,
   output logic                         rsp_search_done
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type                        state_ff, state_in;
   logic [dwmd_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [dwmd_pkg::IDX_W-1:0]       wp_ff, wp_in;
   logic [dwmd_pkg::RUN_W-1:0]       run_ff, run_in;
   logic [dwmd_pkg::POS_W-1:0]       count_ff, count_in;
   logic                             found_ff, found_in;
   logic [dwmd_pkg::SYM_W-1:0]       sym_ff, sym_in;
   logic [dwmd_pkg::IDX_W-1:0]       scan_len_ff, scan_len_in;
   logic [dwmd_pkg::IDX_W:0]         issue_k_ff, issue_k_in;
   logic                             rd_v_ff, rd_v_in;
   logic [dwmd_pkg::IDX_W-1:0]       rd_k_ff, rd_k_in;
   logic                             match_ff, match_in;
   logic [dwmd_pkg::RUN_W:0]         dist_ff, dist_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             marker_ff, marker_in;
   logic [dwmd_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic                             done_ff, done_in;

   logic                             accept;
   logic                             out_free;
   logic                             ram_rd_en;
   logic [dwmd_pkg::IDX_W-1:0]       ram_rd_addr;
   logic [dwmd_pkg::SYM_W-1:0]       ram_rd_data;
   logic [dwmd_pkg::IDX_W-1:0]       ram_wr_addr;
   logic [dwmd_pkg::RUN_W-1:0]       n_eff;
   logic [dwmd_pkg::IDX_W-1:0]       scan_next;
   logic [dwmd_pkg::RUN_W:0]         run_cand;
   logic [dwmd_pkg::RUN_W:0]         run_new;

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_marker_found  = marker_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_search_done   = done_ff;

   assign ram_wr_addr = wp_ff + dwmd_pkg::IDX_W'(1);
   assign ram_rd_en   = (state_ff == ST_SCAN) && (issue_k_ff <= {1'b0, scan_len_ff});
   assign ram_rd_addr = wp_ff - issue_k_ff[dwmd_pkg::IDX_W-1:0];

   dwmd_ram #(
      .WIDTH(dwmd_pkg::SYM_W),
      .DEPTH(dwmd_pkg::MAX_WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(ram_wr_addr),
      .wr_data(req_symbol),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // clamp configured length to 2..MAX_WINDOW
   always_comb begin
      if (len_ff < dwmd_pkg::LEN_W'(dwmd_pkg::LEN_MIN)) begin
         n_eff = dwmd_pkg::RUN_W'(dwmd_pkg::LEN_MIN);
      end else if (32'(len_ff) > 32'(dwmd_pkg::MAX_WINDOW)) begin
         n_eff = dwmd_pkg::RUN_W'(dwmd_pkg::MAX_WINDOW);
      end else begin
         n_eff = dwmd_pkg::RUN_W'(len_ff);
      end
   end

   // prior entries to compare: min(run, MAX_WINDOW-1)
   always_comb begin
      if (32'(run_ff) > 32'(dwmd_pkg::MAX_WINDOW - 1)) begin
         scan_next = dwmd_pkg::IDX_W'(dwmd_pkg::MAX_WINDOW - 1);
      end else begin
         scan_next = dwmd_pkg::IDX_W'(run_ff);
      end
   end

   assign run_cand = {1'b0, run_ff} + (dwmd_pkg::RUN_W+1)'(1);
   assign run_new  = (run_cand < dist_ff) ? run_cand : dist_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      wp_in        = wp_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      sym_in       = sym_ff;
      scan_len_in  = scan_len_ff;
      issue_k_in   = issue_k_ff;
      rd_v_in      = 1'b0;
      rd_k_in      = rd_k_ff;
      match_in     = match_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      marker_in    = marker_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in      = req_symbol;
               wp_in       = ram_wr_addr;
               count_in    = (count_ff == dwmd_pkg::POS_MAX) ? count_ff
                                                             : count_ff + 1'b1;
               scan_len_in = scan_next;
               issue_k_in  = (dwmd_pkg::IDX_W+1)'(1);
               match_in    = 1'b0;
               dist_in     = (dwmd_pkg::RUN_W+1)'(dwmd_pkg::MAX_WINDOW);
               state_in    = (scan_next == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               rd_v_in    = 1'b1;
               rd_k_in    = issue_k_ff[dwmd_pkg::IDX_W-1:0];
               issue_k_in = issue_k_ff + 1'b1;
            end
            if (rd_v_ff) begin
               if (!match_ff && (ram_rd_data == sym_ff)) begin
                  match_in = 1'b1;
                  dist_in  = (dwmd_pkg::RUN_W+1)'(rd_k_ff);
               end
               if (rd_k_ff == scan_len_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               run_in       = dwmd_pkg::RUN_W'(run_new);
               marker_in    = !found_ff && (run_new >= {1'b0, n_eff});
               done_in      = found_ff || (run_new >= {1'b0, n_eff});
               found_in     = done_in;
               pos_in       = count_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= dwmd_pkg::LEN_RESET;
         wp_ff        <= '0;
         run_ff       <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         run_ff       <= run_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff      <= sym_in;
      scan_len_ff <= scan_len_in;
      issue_k_ff  <= issue_k_in;
      rd_k_ff     <= rd_k_in;
      match_ff    <= match_in;
      dist_ff     <= dist_in;
      marker_ff   <= marker_in;
      pos_ff      <= pos_in;
      done_ff     <= done_in;
   end

endmodule

### hdl/dwmd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dwmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
